### design/mrifc_pkg.sv
// Shared types, codes and constants for the Modbus read-input framer/checker.
// Used by mrifc_tx, mrifc_rx and modbus_read_input_framer_checker.
package mrifc_pkg;

  localparam logic       CMD_REQUEST     = 1'b0;
  localparam logic       CMD_RX_BYTE     = 1'b1;
  localparam logic       KIND_TX         = 1'b0;
  localparam logic       KIND_VERDICT    = 1'b1;
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SHORT    = 2'd1;
  localparam logic [1:0] STATUS_BAD_HDR  = 2'd2;
  localparam logic [7:0] FUNC_READ_INPUT = 8'h04;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam int         MIN_RESPONSE    = 7;
  localparam logic [7:0] SLAVE_ADDR_RST  = 8'd1;

  localparam logic [2:0] IDX_ADDR    = 3'd0;
  localparam logic [2:0] IDX_FUNC    = 3'd1;
  localparam logic [2:0] IDX_START_H = 3'd2;
  localparam logic [2:0] IDX_START_L = 3'd3;
  localparam logic [2:0] IDX_QTY_H   = 3'd4;
  localparam logic [2:0] IDX_QTY_L   = 3'd5;
  localparam logic [2:0] IDX_CRC_L   = 3'd6;
  localparam logic [2:0] IDX_CRC_H   = 3'd7;

  typedef struct packed {
    logic        cmd;
    logic [15:0] start_register;
    logic [15:0] quantity;
    logic [7:0]  rx_byte;
    logic        rx_last;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [1:0]  status;
    logic [15:0] read_value;
  } out_word_t;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
    logic       last;
  } rx_step_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] read_value;
  } verdict_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### design/mrifc_tx.sv
// Request frame serializer: emits the eight frame bytes one per advance,
// folding the six header bytes into the CRC, one per advance. Depends on mrifc_pkg.
module mrifc_tx (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic [7:0]  slave_address,
  input  logic [15:0] start_register,
  input  logic [15:0] quantity,
  output logic [7:0]  tx_byte,
  output logic        tx_last
);
  import mrifc_pkg::*;

  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_base;

  always_comb begin
    case (idx_r)
      IDX_ADDR:    tx_byte = slave_address;
      IDX_FUNC:    tx_byte = FUNC_READ_INPUT;
      IDX_START_H: tx_byte = start_register[15:8];
      IDX_START_L: tx_byte = start_register[7:0];
      IDX_QTY_H:   tx_byte = quantity[15:8];
      IDX_QTY_L:   tx_byte = quantity[7:0];
      IDX_CRC_L:   tx_byte = crc_r[7:0];
      IDX_CRC_H:   tx_byte = crc_r[15:8];
      default:     tx_byte = 8'd0;
    endcase
  end

  assign tx_last  = (idx_r == IDX_CRC_H);
  assign crc_base = (idx_r == IDX_ADDR) ? CRC_INIT : crc_r;

  always_comb begin
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    if (adv) begin
      idx_nxt = idx_r + 3'd1;
      if (idx_r < IDX_CRC_L) begin
        crc_nxt = crc_update(crc_base, tx_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= IDX_ADDR;
    end else begin
      idx_r <= idx_nxt;
    end
    crc_r <= crc_nxt;
  end

endmodule

### design/mrifc_rx.sv
// Response checker: counts received bytes, keeps header and value bytes,
// and forms the verdict for the marked last byte. Depends on mrifc_pkg.
module mrifc_rx #(
  parameter int RX_BUFFER_BYTES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mrifc_pkg::rx_step_t step,
  input  logic [7:0]          slave_address,
  output mrifc_pkg::verdict_t verdict
);
  import mrifc_pkg::*;

  localparam int CNT_W = $clog2(RX_BUFFER_BYTES + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] func_r, func_nxt;
  logic [7:0] val_hi_r, val_hi_nxt;
  logic [7:0] val_lo_r, val_lo_nxt;

  always_comb begin
    count_nxt  = count_r;
    addr_nxt   = addr_r;
    func_nxt   = func_r;
    val_hi_nxt = val_hi_r;
    val_lo_nxt = val_lo_r;
    if (count_r < CNT_W'(RX_BUFFER_BYTES)) begin
      if (count_r == CNT_W'(0)) addr_nxt = step.data;
      if (count_r == CNT_W'(1)) func_nxt = step.data;
      if (count_r == CNT_W'(3)) val_hi_nxt = step.data;
      if (count_r == CNT_W'(4)) val_lo_nxt = step.data;
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_comb begin
    verdict.read_value = 16'd0;
    if (count_nxt < CNT_W'(MIN_RESPONSE)) begin
      verdict.status = STATUS_SHORT;
    end else if (addr_nxt != slave_address || func_nxt != FUNC_READ_INPUT) begin
      verdict.status = STATUS_BAD_HDR;
    end else begin
      verdict.status     = STATUS_OK;
      verdict.read_value = {val_hi_nxt, val_lo_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      addr_r   <= 8'd0;
      func_r   <= 8'd0;
      val_hi_r <= 8'd0;
      val_lo_r <= 8'd0;
    end else if (step.en) begin
      if (step.last) begin
        count_r  <= '0;
        addr_r   <= 8'd0;
        func_r   <= 8'd0;
        val_hi_r <= 8'd0;
        val_lo_r <= 8'd0;
      end else begin
        count_r  <= count_nxt;
        addr_r   <= addr_nxt;
        func_r   <= func_nxt;
        val_hi_r <= val_hi_nxt;
        val_lo_r <= val_lo_nxt;
      end
    end
  end

endmodule

### design/modbus_read_input_framer_checker.sv
// Modbus RTU master for function 0x04 (read input registers). A request word
// (cmd 0) yields eight transmit words, one per cycle while the output is taken,
// ending with the CRC-16/MODBUS low then high byte; the request sits in the input
// register until its last byte is sent, so the serializer's counter sets its rate.
// A response byte word (cmd 1) is taken at once, but the word marked last waits
// for a free output slot and yields one verdict word (status 0 ok, 1 short, 2 bad
// address/function). The response CRC is not checked. The slave address register
// lies at byte address 0 (reset 1). Depends on mrifc_pkg, mrifc_tx and mrifc_rx.
module modbus_read_input_framer_checker #(
  parameter int RX_BUFFER_BYTES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mrifc_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mrifc_pkg::out_word_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import mrifc_pkg::*;

  in_word_t  item_r;
  logic      item_v_r, item_v_nxt;
  out_word_t out_r, out_nxt;
  logic      out_v_r, out_v_nxt;
  logic [7:0] slave_addr_r;

  logic       slot_free, is_req, tx_adv, item_done, load;
  logic [7:0] tx_byte;
  logic       tx_last;
  rx_step_t   step;
  verdict_t   verdict;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, slave_addr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= SLAVE_ADDR_RST;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      slave_addr_r <= pwdata[7:0];
    end
  end

  assign slot_free = !out_v_r || out_ready;
  assign is_req    = (item_r.cmd == CMD_REQUEST);
  assign tx_adv    = item_v_r && is_req && slot_free;
  assign step.en   = item_v_r && !is_req && (!item_r.rx_last || slot_free);
  assign step.data = item_r.rx_byte;
  assign step.last = item_r.rx_last;
  assign item_done = (tx_adv && tx_last) || step.en;
  assign in_ready  = !item_v_r || item_done;
  assign load      = tx_adv || (step.en && item_r.rx_last);

  mrifc_tx u_tx (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (tx_adv),
    .slave_address  (slave_addr_r),
    .start_register (item_r.start_register),
    .quantity       (item_r.quantity),
    .tx_byte        (tx_byte),
    .tx_last        (tx_last)
  );

  mrifc_rx #(
    .RX_BUFFER_BYTES (RX_BUFFER_BYTES)
  ) u_rx (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .slave_address (slave_addr_r),
    .verdict       (verdict)
  );

  always_comb begin
    out_nxt = out_r;
    if (tx_adv) begin
      out_nxt.kind       = KIND_TX;
      out_nxt.tx_byte    = tx_byte;
      out_nxt.tx_last    = tx_last;
      out_nxt.status     = STATUS_OK;
      out_nxt.read_value = 16'd0;
    end else if (load) begin
      out_nxt.kind       = KIND_VERDICT;
      out_nxt.tx_byte    = 8'd0;
      out_nxt.tx_last    = 1'b0;
      out_nxt.status     = verdict.status;
      out_nxt.read_value = verdict.read_value;
    end
  end

  always_comb begin
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
    if (in_valid && in_ready) begin
      item_v_nxt = 1'b1;
    end else if (item_done) begin
      item_v_nxt = 1'b0;
    end else begin
      item_v_nxt = item_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
